// File: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/rasst_pkg.sv
`default_nettype none

package rasst_pkg;

   localparam int DATA_W           = 64;
   localparam int FIELD_W          = 11;
   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam logic [FIELD_W-1:0] COUNT_RESET = 11'd1024;

   typedef enum logic {
      OP_ADD = 1'b0,
      OP_SUM = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      PH_ENTER,
      PH_LEFT,
      PH_RIGHT
   } phase_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EVAL,
      S_COV,
      S_PD_RD,
      S_PD_LMUL,
      S_PD_LWR,
      S_PD_RMUL,
      S_PD_RWR,
      S_PD_CLR,
      S_UP0,
      S_UP1,
      S_POP,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// File: src/rasst_ram.sv
`default_nettype none

module rasst_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: src/range_add_range_sum_tree.sv
// Range-add / range-sum store over positions 1..element_count (at most
// MAX_ELEMENTS), kept as a lazy segment tree in two RAMs (node sums and
// pending adds, 4*MAX_ELEMENTS deep). Input words arrive on req_valid/req_ready.
// An add word (opcode 0) adds req_add_value to every position in
// [req_range_low, req_range_high] and gives no response. A sum word (opcode 1)
// gives one rsp word carrying the wrapped 64-bit sum over the range, 0 for an
// empty or disjoint range. One word is worked on at a time; req_ready is high
// only while idle. A word walks the tree depth first with a small stack; the
// RAMs are read through one read address shared by both. A visited node is
// skipped when disjoint, read (and for an add rewritten) when covered, and split
// otherwise, any pending add first being pushed down to both children; after an
// add splits a node, its sum is rebuilt from the sums of its two children.
// The response sits in an output register; the next word is accepted while
// it waits, and a later sum stalls at its end until rsp_ready frees it.
// After reset both RAMs are cleared, one entry per cycle, over all
// 4*MAX_ELEMENTS entries (4096 by default), before the first word is taken.
// element_count resets to 1024; it is to be written through csr_wr_en/csr_wr_data
// only while idle, which the block itself does not enforce.
`default_nettype none
`include "assert_macros.svh"

module range_add_range_sum_tree
   import rasst_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_opcode,
   input  wire logic [FIELD_W-1:0]        req_range_low,
   input  wire logic [FIELD_W-1:0]        req_range_high,
   input  wire logic signed [DATA_W-1:0]  req_add_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [DATA_W-1:0]       rsp_range_sum,
   input  wire logic                      csr_wr_en,
   input  wire logic [FIELD_W-1:0]        csr_wr_data
);

   localparam int DEPTH = 4 * MAX_ELEMENTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(MAX_ELEMENTS + 1);
   localparam int CW    = (PW > FIELD_W) ? PW : FIELD_W;
   localparam int STACK_DEPTH = $clog2(MAX_ELEMENTS) + 1;
   localparam int SPW   = $clog2(STACK_DEPTH + 1);
   localparam int SIW   = $clog2(STACK_DEPTH);

   typedef struct packed {
      logic [AW-1:0] node;
      logic [PW-1:0] lo;
      logic [PW-1:0] hi;
      phase_type     phase;
   } frame_type;

   state_type          state_ff, state_in;
   logic [SPW-1:0]     sp_ff, sp_in;
   frame_type          stk_ff [STACK_DEPTH];
   logic               stk_we;
   frame_type          stk_wdata;
   frame_type          cur_ff, cur_in;
   logic               op_ff, op_in;
   logic [CW-1:0]      a_ff, a_in, b_ff, b_in;
   logic [DATA_W-1:0]  amt_ff, amt_in;
   logic [DATA_W-1:0]  acc_ff, acc_in;
   logic [DATA_W-1:0]  pd_ff, pd_in;
   logic [DATA_W-1:0]  rs_ff, rs_in, rp_ff, rp_in;
   logic [DATA_W-1:0]  prod_ff, prod_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [FIELD_W-1:0] count_ff;
   logic               out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]  out_sum_ff, out_sum_in;

   logic               s_we, p_we, rd_en;
   logic [AW-1:0]      s_waddr, p_waddr, rd_addr;
   logic [DATA_W-1:0]  s_wdata, p_wdata, s_q, p_q;

   logic               accept;
   logic [PW-1:0]      eff_n;
   logic [AW-1:0]      left_node, right_node;
   logic [PW:0]        lh_sum;
   logic [PW-1:0]      mid, len, len_l, len_r;
   logic [CW-1:0]      lo_c, hi_c;
   logic               disjoint, covered, load_out;
   logic [SIW-1:0]     top_idx;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_range_sum = out_sum_ff;

   assign eff_n = (CW'(count_ff) > CW'(MAX_ELEMENTS)) ? PW'(MAX_ELEMENTS)
                                                      : PW'(CW'(count_ff));
   assign left_node  = {cur_ff.node[AW-2:0], 1'b0};
   assign right_node = {cur_ff.node[AW-2:0], 1'b1};
   assign lh_sum  = {1'b0, cur_ff.lo} + {1'b0, cur_ff.hi};
   assign mid     = lh_sum[PW:1];
   assign len     = cur_ff.hi - cur_ff.lo + PW'(1);
   assign len_l   = mid - cur_ff.lo + PW'(1);
   assign len_r   = cur_ff.hi - mid;
   assign lo_c    = CW'(cur_ff.lo);
   assign hi_c    = CW'(cur_ff.hi);
   assign disjoint = (hi_c < a_ff) || (b_ff < lo_c);
   assign covered  = (a_ff <= lo_c) && (hi_c <= b_ff);
   assign top_idx  = SIW'(sp_ff - SPW'(1));
   assign load_out = (state_ff == S_DONE) && (!out_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (eff_n != '0)             state_in = S_EVAL;
               else if (req_opcode == OP_SUM) state_in = S_DONE;
            end
         end
         S_EVAL: begin
            unique case (cur_ff.phase)
               PH_ENTER: begin
                  if (disjoint)     state_in = S_POP;
                  else if (covered) state_in = S_COV;
                  else              state_in = S_PD_RD;
               end
               PH_LEFT:  state_in = S_EVAL;
               PH_RIGHT: state_in = (op_ff == OP_ADD) ? S_UP0 : S_POP;
               default:  state_in = S_POP;
            endcase
         end
         S_COV:     state_in = S_POP;
         S_PD_RD:   state_in = (p_q == '0) ? S_PD_CLR : S_PD_LMUL;
         S_PD_LMUL: state_in = S_PD_LWR;
         S_PD_LWR:  state_in = S_PD_RMUL;
         S_PD_RMUL: state_in = S_PD_RWR;
         S_PD_RWR:  state_in = S_PD_CLR;
         S_PD_CLR:  state_in = S_EVAL;
         S_UP0:     state_in = S_UP1;
         S_UP1:     state_in = S_POP;
         S_POP: begin
            if (sp_ff != '0)           state_in = S_EVAL;
            else if (op_ff == OP_SUM)  state_in = S_DONE;
            else                       state_in = S_IDLE;
         end
         S_DONE: begin
            if (load_out) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      sp_in   = sp_ff;
      cur_in  = cur_ff;
      op_in   = op_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      amt_in  = amt_ff;
      acc_in  = acc_ff;
      pd_in   = pd_ff;
      rs_in   = rs_ff;
      rp_in   = rp_ff;
      prod_in = prod_ff;
      clr_in  = clr_ff;
      stk_we    = 1'b0;
      stk_wdata = cur_ff;
      s_we    = 1'b0;
      p_we    = 1'b0;
      s_waddr = cur_ff.node;
      p_waddr = cur_ff.node;
      s_wdata = '0;
      p_wdata = '0;
      rd_en   = 1'b0;
      rd_addr = cur_ff.node;
      out_sum_in   = load_out ? acc_ff : out_sum_ff;
      out_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      unique case (state_ff)
         S_CLEAR: begin
            s_we    = 1'b1;
            p_we    = 1'b1;
            s_waddr = clr_ff;
            p_waddr = clr_ff;
            clr_in  = clr_ff + AW'(1);
         end
         S_IDLE: begin
            if (accept) begin
               op_in  = req_opcode;
               a_in   = CW'(req_range_low);
               b_in   = CW'(req_range_high);
               amt_in = req_add_value;
               acc_in = '0;
               sp_in  = '0;
               cur_in = '{node: AW'(1), lo: PW'(1), hi: eff_n, phase: PH_ENTER};
            end
         end
         S_EVAL: begin
            unique case (cur_ff.phase)
               PH_ENTER: begin
                  if (!disjoint) begin
                     rd_en = 1'b1;
                  end
                  prod_in = amt_ff * DATA_W'(len);
               end
               PH_LEFT: begin
                  stk_we          = 1'b1;
                  stk_wdata.phase = PH_RIGHT;
                  sp_in  = sp_ff + SPW'(1);
                  cur_in = '{node: right_node, lo: mid + PW'(1), hi: cur_ff.hi,
                             phase: PH_ENTER};
               end
               PH_RIGHT: begin
                  if (op_ff == OP_ADD) begin
                     rd_en   = 1'b1;
                     rd_addr = left_node;
                  end
               end
               default: begin
               end
            endcase
         end
         S_COV: begin
            if (op_ff == OP_SUM) begin
               acc_in = acc_ff + s_q;
            end else begin
               s_we    = 1'b1;
               p_we    = 1'b1;
               s_wdata = s_q + prod_ff;
               p_wdata = p_q + amt_ff;
            end
         end
         S_PD_RD: begin
            pd_in   = p_q;
            rd_en   = (p_q != '0);
            rd_addr = left_node;
         end
         S_PD_LMUL: begin
            rs_in   = s_q;
            rp_in   = p_q;
            prod_in = pd_ff * DATA_W'(len_l);
         end
         S_PD_LWR: begin
            s_we    = 1'b1;
            p_we    = 1'b1;
            s_waddr = left_node;
            p_waddr = left_node;
            s_wdata = rs_ff + prod_ff;
            p_wdata = rp_ff + pd_ff;
            rd_en   = 1'b1;
            rd_addr = right_node;
         end
         S_PD_RMUL: begin
            rs_in   = s_q;
            rp_in   = p_q;
            prod_in = pd_ff * DATA_W'(len_r);
         end
         S_PD_RWR: begin
            s_we    = 1'b1;
            p_we    = 1'b1;
            s_waddr = right_node;
            p_waddr = right_node;
            s_wdata = rs_ff + prod_ff;
            p_wdata = rp_ff + pd_ff;
         end
         S_PD_CLR: begin
            p_we            = 1'b1;
            p_wdata         = '0;
            stk_we          = 1'b1;
            stk_wdata.phase = PH_LEFT;
            sp_in  = sp_ff + SPW'(1);
            cur_in = '{node: left_node, lo: cur_ff.lo, hi: mid, phase: PH_ENTER};
         end
         S_UP0: begin
            rs_in   = s_q;
            rd_en   = 1'b1;
            rd_addr = right_node;
         end
         S_UP1: begin
            s_we    = 1'b1;
            s_wdata = rs_ff + s_q;
         end
         S_POP: begin
            if (sp_ff != '0) begin
               cur_in = stk_ff[top_idx];
               sp_in  = sp_ff - SPW'(1);
            end
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         sp_ff        <= '0;
         count_ff     <= COUNT_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      op_ff      <= op_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      amt_ff     <= amt_in;
      acc_ff     <= acc_in;
      pd_ff      <= pd_in;
      rs_ff      <= rs_in;
      rp_ff      <= rp_in;
      prod_ff    <= prod_in;
      out_sum_ff <= out_sum_in;
      if (stk_we) begin
         stk_ff[sp_ff[SIW-1:0]] <= stk_wdata;
      end
   end

   rasst_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_sum_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (s_q)
   );

   rasst_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_pend_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (p_q)
   );

   `ASSERT_CLK(a_stack_bound, clock, reset, sp_ff <= SPW'(STACK_DEPTH), "stack overflow")
   `ASSERT_CLK(a_no_collide, clock, reset, (s_we && rd_en) |-> (s_waddr != rd_addr), "sum RAM read and write collide")
   `ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> (state_ff == S_CLEAR && !rsp_valid), "reset does not start the clearing sweep")

endmodule

`default_nettype wire

// File: test/tb_range_add_range_sum_tree.sv
`timescale 1ns / 100ps

module tb_range_add_range_sum_tree;
   import rasst_pkg::*;

   localparam int NMAX = MAX_ELEMENTS_DEF;
   localparam longint LIMIT = 5_000_000;

   typedef struct {
      opcode_type          op;
      logic [FIELD_W-1:0]  lo;
      logic [FIELD_W-1:0]  hi;
      logic [DATA_W-1:0]   amt;
      logic                chk;
      logic [DATA_W-1:0]   sum;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_opcode = 1'b0;
   logic [FIELD_W-1:0] req_range_low = '0;
   logic [FIELD_W-1:0] req_range_high = '0;
   logic signed [DATA_W-1:0] req_add_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_range_sum;
   logic csr_wr_en = 1'b0;
   logic [FIELD_W-1:0] csr_wr_data = '0;

   logic [DATA_W-1:0] tree_sum_mem[4*NMAX];
   logic [DATA_W-1:0] tree_pend_mem[4*NMAX];
   logic [FIELD_W-1:0] count_reg;
   logic [DATA_W-1:0] sum_queue[$];
   int errors = 0;
   int words_sent = 0;
   int sums_seen = 0;
   longint cycles = 0;
   bit stim_done = 0;

   range_add_range_sum_tree u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic void node_add(int nd, int lo, int hi, logic [DATA_W-1:0] amt);
      tree_pend_mem[nd] += amt;
      tree_sum_mem[nd] += amt * DATA_W'(hi - lo + 1);
   endfunction

   function automatic void node_push(int nd, int lo, int hi);
      logic [DATA_W-1:0] amt;
      int mid;
      amt = tree_pend_mem[nd];
      mid = (lo + hi) / 2;
      if (amt == 0) return;
      node_add(2*nd, lo, mid, amt);
      node_add(2*nd+1, mid+1, hi, amt);
      tree_pend_mem[nd] = 0;
   endfunction

   function automatic void range_add(int nd, int lo, int hi, int a, int b,
                                     logic [DATA_W-1:0] amt);
      int mid;
      if (hi < a || b < lo) return;
      if (a <= lo && hi <= b) begin
         node_add(nd, lo, hi, amt);
         return;
      end
      node_push(nd, lo, hi);
      mid = (lo + hi) / 2;
      range_add(2*nd, lo, mid, a, b, amt);
      range_add(2*nd+1, mid+1, hi, a, b, amt);
      tree_sum_mem[nd] = tree_sum_mem[2*nd] + tree_sum_mem[2*nd+1];
   endfunction

   function automatic logic [DATA_W-1:0] range_total(int nd, int lo, int hi, int a, int b);
      int mid;
      if (hi < a || b < lo) return 0;
      if (a <= lo && hi <= b) return tree_sum_mem[nd];
      node_push(nd, lo, hi);
      mid = (lo + hi) / 2;
      return range_total(2*nd, lo, mid, a, b) + range_total(2*nd+1, mid+1, hi, a, b);
   endfunction

   function automatic logic [DATA_W-1:0] predict_word(opcode_type op, int a, int b,
                                                      logic [DATA_W-1:0] amt);
      int n;
      n = (count_reg > NMAX) ? NMAX : int'(count_reg);
      if (op == OP_ADD) begin
         if (n != 0) range_add(1, 1, n, a, b, amt);
         return 0;
      end
      return (n != 0) ? range_total(1, 1, n, a, b) : 0;
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                  logic [DATA_W-1:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sums_seen++;
         if (sum_queue.size() == 0) report_mismatch("unexpected word", rsp_range_sum, 'x);
         else begin
            logic [DATA_W-1:0] want;
            want = sum_queue.pop_front();
            if (rsp_range_sum !== want) report_mismatch("range_sum", rsp_range_sum, want);
         end
      end
   end

   initial begin
      int g;
      forever begin
         @(negedge clock);
         if (stim_done && sum_queue.size() == 0) rsp_ready <= 1'b1;
         else if (rsp_ready && $urandom_range(0, 3) != 0) rsp_ready <= 1'b1;
         else begin
            g = gap_len();
            if (g == 0) rsp_ready <= 1'b1;
            else begin
               rsp_ready <= 1'b0;
               repeat (g - 1) @(negedge clock);
            end
         end
      end
   end

   task automatic send_word(opcode_type op, logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi,
                            logic [DATA_W-1:0] amt, bit chk, logic [DATA_W-1:0] want);
      logic [DATA_W-1:0] pred;
      @(negedge clock);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_range_low <= lo;
      req_range_high <= hi;
      req_add_value <= amt;
      do @(posedge clock); while (!(req_valid && req_ready));
      pred = predict_word(op, int'(lo), int'(hi), amt);
      if (op == OP_SUM) begin
         if (chk && pred !== want) report_mismatch("table row", pred, want);
         sum_queue.push_back(pred);
      end
      words_sent++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (sum_queue.size() != 0) @(negedge clock);
      repeat (600) @(negedge clock);
   endtask

   task automatic write_count(logic [FIELD_W-1:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      count_reg = v;
   endtask

   task automatic random_phase(int items, int n);
      opcode_type op;
      int a, b;
      logic [DATA_W-1:0] amt;
      for (int i = 0; i < items; i++) begin
         op = opcode_type'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0: begin a = $urandom_range(0, 2047); b = $urandom_range(0, 2047); end
            1: begin a = $urandom_range(1, n + 1); b = a - 1; end
            default: begin
               a = $urandom_range(1, n > 0 ? n : 1);
               b = $urandom_range(a, n > a ? n : a);
            end
         endcase
         case ($urandom_range(0, 3))
            0: amt = {$urandom, $urandom};
            1: amt = 64'($signed($urandom_range(0, 200)) - 100);
            default: amt = 64'($urandom_range(0, 1000));
         endcase
         if ($urandom_range(0, 5) == 0) amt = ~amt;
         send_word(op, FIELD_W'(a), FIELD_W'(b), amt, 1'b0, '0);
         repeat (gap_len()) @(negedge clock);
      end
   endtask

   stim_row_type rows[$];

   initial begin
      foreach (tree_sum_mem[i]) begin
         tree_sum_mem[i] = 0;
         tree_pend_mem[i] = 0;
      end
      count_reg = COUNT_RESET;
      rows = '{
         '{OP_SUM, 11'd1, 11'd1024, 64'd0, 1'b1, 64'd0},
         '{OP_ADD, 11'd1, 11'd1024, 64'd1, 1'b0, 64'd0},
         '{OP_SUM, 11'd1, 11'd1024, 64'd0, 1'b1, 64'd1024},
         '{OP_SUM, 11'd5, 11'd4, 64'd0, 1'b1, 64'd0},
         '{OP_SUM, 11'd1025, 11'd2047, 64'd0, 1'b1, 64'd0},
         '{OP_ADD, 11'd1000, 11'd2047, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
         '{OP_ADD, 11'd1, 11'd1, 64'h8000_0000_0000_0000, 1'b0, 64'd0},
         '{OP_ADD, 11'd0, 11'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
         '{OP_ADD, 11'd9, 11'd2, 64'd55, 1'b0, 64'd0},
         '{OP_SUM, 11'd0, 11'd2047, 64'd0, 1'b0, 64'd0},
         '{OP_SUM, 11'd1, 11'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
         '{OP_SUM, 11'd1024, 11'd1024, 64'd0, 1'b0, 64'd0},
         '{OP_SUM, 11'd2, 11'd999, 64'd0, 1'b0, 64'd0},
         '{OP_ADD, 11'd2047, 11'd2047, 64'h5555_AAAA_5555_AAAA, 1'b0, 64'd0},
         '{OP_SUM, 11'd500, 11'd1010, 64'd0, 1'b0, 64'd0}
      };
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         send_word(rows[i].op, rows[i].lo, rows[i].hi, rows[i].amt, rows[i].chk, rows[i].sum);
         repeat (gap_len()) @(negedge clock);
      end
      random_phase(500, 1024);
      drain();
      random_phase(100, 1024);
      write_count(11'd0);
      send_word(OP_ADD, 11'd1, 11'd5, 64'd7, 1'b0, '0);
      send_word(OP_SUM, 11'd1, 11'd2047, 64'd0, 1'b1, 64'd0);
      write_count(11'd1);
      random_phase(100, 1);
      write_count(11'd2047);
      random_phase(300, 1024);
      write_count(11'd37);
      random_phase(400, 37);
      write_count(11'd1000);
      random_phase(300, 1000);
      write_count(11'd2);
      random_phase(150, 2);
      drain();
      stim_done = 1;
      $display("Sent %0d words, checked %0d sums over element counts 1024, 0, 1, 2047,",
               words_sent, sums_seen);
      $display("37, 1000 and 2, with random stalls on both channels.");
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
